@@ hw/rtl/periodic_task_scheduler_tick_defines.svh @@
// Assertion macros shared by the scheduler's checker.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef PERIODIC_TASK_SCHEDULER_TICK_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_TICK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pts_pkg.sv @@
// Package for the periodic task scheduler: widths, defaults and codes.
// No dependencies; the scheduler's interfaces, modules and checker depend on it.
`default_nettype none

package pts_pkg;

  localparam int unsigned TASKS_DEF      = 6;
  localparam int unsigned TIME_BITS_DEF  = 8;
  localparam int unsigned CYCLE_BITS_DEF = 16;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned OUT_CYCLE_W = 16;
  localparam int unsigned OUT_TASK_W  = 3;

  localparam logic [MODE_W-1:0]     MODE_RESET    = '0;
  localparam logic [CNT_W-1:0]      COUNT_RESET   = 3'd6;
  localparam logic [CFG_DATA_W-1:0] PERIOD_RESET  = 48'h0101_0101_0101;
  localparam logic [CFG_DATA_W-1:0] COMPUTE_RESET = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_RM  = 2'd0,
    MODE_EDF = 2'd1,
    MODE_LLF = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 4'd0,
    REG_COUNT   = 4'd1,
    REG_PERIOD  = 4'd2,
    REG_COMPUTE = 4'd3
  } reg_idx_t;

  // Per-task status handed from a lane to the top level.
  typedef struct packed {
    logic miss;  // released while a started job is unfinished
    logic rdy;   // ready flag after this tick's release
    logic cand;  // task in use and ready, may be picked
  } lane_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/pts_if.sv @@
// Handshake channels of the periodic task scheduler: tick input, result
// output and register write port. Depends on pts_pkg.
`default_nettype none

interface pts_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface pts_out_if;
  logic                           valid;
  logic                           ready;
  logic [pts_pkg::OUT_CYCLE_W-1:0] cycle_index;
  logic [pts_pkg::OUT_TASK_W-1:0]  task_run;
  logic                           ran_flag;
  logic                           deadline_missed;
  modport source (output valid, output cycle_index, output task_run,
                  output ran_flag, output deadline_missed, input ready);
  modport sink   (input valid, input cycle_index, input task_run,
                  input ran_flag, input deadline_missed, output ready);
endinterface

interface pts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pts_pkg::CFG_IDX_W-1:0]  index;
  logic [pts_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pts_lane.sv @@
// One task's release, deadline-miss check and scheduling key for one tick.
// Purely combinational; depends on pts_pkg.
`default_nettype none

module pts_lane #(
  parameter int unsigned TIME_BITS  = pts_pkg::TIME_BITS_DEF,
  parameter int unsigned CYCLE_BITS = pts_pkg::CYCLE_BITS_DEF,
  parameter int unsigned KEY_W      = ((TIME_BITS > CYCLE_BITS) ? TIME_BITS : CYCLE_BITS) + 2
) (
  input  wire logic                         clr,
  input  wire logic                         in_use,
  input  wire logic [pts_pkg::MODE_W-1:0]   mode,
  input  wire logic [CYCLE_BITS-1:0]        now,
  input  wire logic [TIME_BITS-1:0]         per_raw,
  input  wire logic [TIME_BITS-1:0]         ct,
  input  wire logic [TIME_BITS-1:0]         rw_r,
  input  wire logic                         rdy_r,
  input  wire logic [TIME_BITS-1:0]         cd_r,
  input  wire logic [CYCLE_BITS-1:0]        dl_r,
  output pts_pkg::lane_flags_t              flags,
  output logic [TIME_BITS-1:0]              rw_rel,
  output logic [TIME_BITS-1:0]              cd_nxt,
  output logic [CYCLE_BITS-1:0]             dl_nxt,
  output logic signed [KEY_W-1:0]           key
);
  import pts_pkg::*;

  localparam int unsigned W = KEY_W - 2;

  logic [TIME_BITS-1:0]  rw_e, cd_e, per;
  logic [CYCLE_BITS-1:0] dl_e, per_c, ahead;
  logic [W-1:0]          per_w, ahead_w, rw_w;
  logic                  rdy_e, rel;

  // A restart tick sees all task state as cleared.
  assign rw_e  = clr ? '0 : rw_r;
  assign cd_e  = clr ? '0 : cd_r;
  assign dl_e  = clr ? '0 : dl_r;
  assign rdy_e = clr ? 1'b0 : rdy_r;

  // A zero period behaves as a period of one.
  assign per   = (per_raw == '0) ? {{(TIME_BITS-1){1'b0}}, 1'b1} : per_raw;
  assign per_w = W'(per);
  assign per_c = per_w[CYCLE_BITS-1:0];

  assign rel    = in_use && (cd_e == '0);
  assign rw_rel = (rel && (rw_e == '0)) ? ct : rw_e;
  assign cd_nxt = rel ? (per - 1'b1) : (in_use ? (cd_e - 1'b1) : cd_e);
  assign dl_nxt = rel ? (now + per_c) : dl_e;

  // Distance to the deadline; for a fresh release it is the period itself.
  assign ahead   = rel ? per_c : (dl_e - now);
  assign ahead_w = W'(ahead);
  assign rw_w    = W'(rw_rel);

  assign flags.miss = rel && (rw_e != '0) && (rw_e < ct);
  assign flags.rdy  = rdy_e || rel;
  assign flags.cand = in_use && (rdy_e || rel);

  always_comb begin
    unique case (mode)
      MODE_EDF: key = $signed({2'b00, ahead_w});
      MODE_LLF: key = $signed({2'b00, ahead_w}) - $signed({2'b00, rw_w});
      default:  key = $signed({2'b00, per_w});
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/pts_pick.sv @@
// Picks the candidate task with the smallest key, lowest index on ties.
// Purely combinational; depends on pts_pkg for defaults.
`default_nettype none

module pts_pick #(
  parameter int unsigned TASKS = pts_pkg::TASKS_DEF,
  parameter int unsigned KEY_W = pts_pkg::CYCLE_BITS_DEF + 2,
  parameter int unsigned IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1
) (
  input  wire logic [TASKS-1:0]        cand,
  input  wire logic signed [KEY_W-1:0] key [TASKS],
  output logic                         found,
  output logic [IDX_W-1:0]             best
);

  logic signed [KEY_W-1:0] best_key;

  always_comb begin
    found    = 1'b0;
    best     = '0;
    best_key = '0;
    for (int i = 0; i < TASKS; i++) begin
      if (cand[i] && (!found || (key[i] < best_key))) begin
        found    = 1'b1;
        best     = IDX_W'(i);
        best_key = key[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/periodic_task_scheduler_tick.sv @@
// Periodic task scheduler, one tick per input transaction. Each accepted
// transaction is one time tick for up to TASKS periodic tasks and yields
// exactly one result transaction: the tick's cycle number, the task that
// ran one unit of work (if any) and the sticky deadline-miss flag. A new
// tick is accepted every clock cycle while the output side is not stalled.
// A result passes from the input register to the result register, where it
// is held while the output side is stalled. The rate is set by the per-tick
// state update loop: release, miss check, pick and retire all settle
// combinationally from the input register into the task state and the
// result register. Registers are to be written through the configuration
// port only while the block is idle; the block does not enforce this, and
// the port is always ready. Register 0 is the mode (0 rate monotonic,
// 1 earliest deadline, 2 least laxity, 3 acts as rate monotonic),
// register 1 the number of tasks in use, registers 2 and 3 the packed
// periods and compute times, TIME_BITS per task. There is no clearing pass
// after reset.
// Depends on pts_pkg, pts_if, pts_lane and pts_pick.
`default_nettype none

module periodic_task_scheduler_tick #(
  parameter int unsigned TASKS      = pts_pkg::TASKS_DEF,
  parameter int unsigned TIME_BITS  = pts_pkg::TIME_BITS_DEF,
  parameter int unsigned CYCLE_BITS = pts_pkg::CYCLE_BITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  pts_cfg_if.sink     cfg_if,
  pts_in_if.sink      in_if,
  pts_out_if.source   out_if
);
  import pts_pkg::*;

  localparam int unsigned W     = (TIME_BITS > CYCLE_BITS) ? TIME_BITS : CYCLE_BITS;
  localparam int unsigned KEY_W = W + 2;
  localparam int unsigned IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned TBL_W = TASKS * TIME_BITS;

  // Configuration registers. Table writes are zero extended and cut to the
  // stored width, so fields beyond the write data read as zero.
  logic [MODE_W-1:0] mode_r;
  logic [CNT_W-1:0]  count_r;
  logic [TBL_W-1:0]  period_r, compute_r;
  logic [TBL_W+CFG_DATA_W-1:0] cfg_ext, period_rst_ext;

  assign cfg_ext        = {{TBL_W{1'b0}}, cfg_if.data};
  assign period_rst_ext = {{TBL_W{1'b0}}, PERIOD_RESET};
  assign cfg_if.ready   = 1'b1;

  // Handshake: an input register feeds the single compute pass, and the
  // result register decouples the output side. The pass fires whenever an
  // input tick is held and the result register is free or being drained.
  logic in_vld_r, in_restart_r, out_vld_r, fire;

  assign fire        = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || fire;

  // Task state, one entry per task, each read only by its own lane.
  logic [TIME_BITS-1:0]  rw_r  [TASKS];
  logic                  rdy_r [TASKS];
  logic [TIME_BITS-1:0]  cd_r  [TASKS];
  logic [CYCLE_BITS-1:0] dl_r  [TASKS];
  logic [CYCLE_BITS-1:0] cycle_r;
  logic                  halted_r;

  // Restart clears the state before this tick is handled as cycle zero.
  logic [CYCLE_BITS-1:0] now;
  logic                  halt_e;

  assign now    = in_restart_r ? '0 : cycle_r;
  assign halt_e = in_restart_r ? 1'b0 : halted_r;

  lane_flags_t             flags  [TASKS];
  logic [TIME_BITS-1:0]    rw_rel [TASKS];
  logic [TIME_BITS-1:0]    rw_nxt [TASKS];
  logic                    rdy_nxt[TASKS];
  logic [TIME_BITS-1:0]    cd_nxt [TASKS];
  logic [CYCLE_BITS-1:0]   dl_nxt [TASKS];
  logic signed [KEY_W-1:0] key    [TASKS];
  logic [TASKS-1:0]        cand, miss_vec, ran_vec;
  logic                    found;
  logic [IDX_W-1:0]        best;

  for (genvar i = 0; i < TASKS; i++) begin : g_lane
    logic in_use, run;

    // Tasks at or above the configured count are frozen and never picked.
    assign in_use = 32'(i) < 32'(count_r);

    pts_lane #(
      .TIME_BITS  (TIME_BITS),
      .CYCLE_BITS (CYCLE_BITS),
      .KEY_W      (KEY_W)
    ) u_lane (
      .clr     (in_restart_r),
      .in_use  (in_use),
      .mode    (mode_r),
      .now     (now),
      .per_raw (period_r[i*TIME_BITS +: TIME_BITS]),
      .ct      (compute_r[i*TIME_BITS +: TIME_BITS]),
      .rw_r    (rw_r[i]),
      .rdy_r   (rdy_r[i]),
      .cd_r    (cd_r[i]),
      .dl_r    (dl_r[i]),
      .flags   (flags[i]),
      .rw_rel  (rw_rel[i]),
      .cd_nxt  (cd_nxt[i]),
      .dl_nxt  (dl_nxt[i]),
      .key     (key[i])
    );

    assign cand[i]     = flags[i].cand;
    assign miss_vec[i] = flags[i].miss;

    // The picked task runs one unit if it has work; if its work is then
    // exhausted (including a zero compute time), it is retired this tick.
    assign run        = found && (best == IDX_W'(i));
    assign ran_vec[i] = run && (rw_rel[i] != '0);
    assign rw_nxt[i]  = ran_vec[i] ? (rw_rel[i] - 1'b1) : rw_rel[i];
    assign rdy_nxt[i] = (run && (rw_nxt[i] == '0)) ? 1'b0 : flags[i].rdy;
  end

  pts_pick #(
    .TASKS (TASKS),
    .KEY_W (KEY_W),
    .IDX_W (IDX_W)
  ) u_pick (
    .cand  (cand),
    .key   (key),
    .found (found),
    .best  (best)
  );

  // A miss raised on this tick halts the schedule at once: no task runs and
  // the cycle counter holds. The rest of the task state does not matter
  // while halted, since only a restart (which clears it) leaves that state.
  logic any_miss, stop, ran;

  assign any_miss = |miss_vec;
  assign stop     = halt_e || any_miss;
  assign ran      = !stop && (|ran_vec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= MODE_RESET;
      count_r   <= COUNT_RESET;
      period_r  <= period_rst_ext[TBL_W-1:0];
      compute_r <= TBL_W'(COMPUTE_RESET);
      cycle_r   <= '0;
      halted_r  <= 1'b0;
      for (int i = 0; i < TASKS; i++) begin
        rw_r[i]  <= '0;
        rdy_r[i] <= 1'b0;
        cd_r[i]  <= '0;
        dl_r[i]  <= '0;
      end
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end

      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end

      if (cfg_if.valid && cfg_if.ready) begin
        unique case (cfg_if.index)
          REG_MODE:    mode_r    <= cfg_if.data[MODE_W-1:0];
          REG_COUNT:   count_r   <= cfg_if.data[CNT_W-1:0];
          REG_PERIOD:  period_r  <= cfg_ext[TBL_W-1:0];
          REG_COMPUTE: compute_r <= cfg_ext[TBL_W-1:0];
          default: ;
        endcase
      end

      if (fire) begin
        halted_r <= stop;
        if (!stop) begin
          cycle_r <= now + 1'b1;
          for (int i = 0; i < TASKS; i++) begin
            rw_r[i]  <= rw_nxt[i];
            rdy_r[i] <= rdy_nxt[i];
            cd_r[i]  <= cd_nxt[i];
            dl_r[i]  <= dl_nxt[i];
          end
        end
      end
    end
  end

  // Payload registers carry no reset.
  logic [OUT_CYCLE_W-1:0] out_cycle_r;
  logic [OUT_TASK_W-1:0]  out_task_r;
  logic                   out_ran_r, out_miss_r;

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_restart_r <= in_if.restart;
    end
    if (fire) begin
      out_cycle_r <= OUT_CYCLE_W'(now);
      out_task_r  <= ran ? OUT_TASK_W'(best) : '0;
      out_ran_r   <= ran;
      out_miss_r  <= stop;
    end
  end

  assign out_if.valid           = out_vld_r;
  assign out_if.cycle_index     = out_cycle_r;
  assign out_if.task_run        = out_task_r;
  assign out_if.ran_flag        = out_ran_r;
  assign out_if.deadline_missed = out_miss_r;

endmodule

`default_nettype wire

@@ hw/rtl/pts_checker.sv @@
// Port-level checker for the periodic task scheduler, bound to the top.
// Depends on pts_pkg and periodic_task_scheduler_tick_defines.svh.
`default_nettype none
`include "periodic_task_scheduler_tick_defines.svh"

module pts_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [pts_pkg::OUT_CYCLE_W-1:0] cycle_index,
  input wire logic [pts_pkg::OUT_TASK_W-1:0]  task_run,
  input wire logic                           ran_flag,
  input wire logic                           deadline_missed
);

  // Ticks accepted whose result has not yet been taken.
  logic [2:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  `PTS_ASSERT_NOW(a_no_invented, out_valid, pend_r != 3'd0, "result without a pending tick")
  `PTS_ASSERT_NOW(a_depth, 1'b1, pend_r <= 3'd2, "more than two ticks in flight")
  `PTS_ASSERT_NOW(a_halt_idle, out_valid && deadline_missed, !ran_flag && task_run == '0, "task ran while halted")
  `PTS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(cycle_index), "stalled result changed")

endmodule

bind periodic_task_scheduler_tick pts_checker u_pts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .cycle_index     (out_if.cycle_index),
  .task_run        (out_if.task_run),
  .ran_flag        (out_if.ran_flag),
  .deadline_missed (out_if.deadline_missed)
);

`default_nettype wire
